// ===== rtl/cgps_pkg.sv =====
// ----------------------------------------------------------------------------
// cgps_pkg
// Shared types and constants of the chaos-game point step block.
// ----------------------------------------------------------------------------
`default_nettype none

package cgps_pkg;

    localparam int COORD_W      = 24;
    localparam int KIND_W       = 2;
    localparam int ENTRY_W      = 4;
    localparam int RANDOM_W     = 15;
    localparam int OUT_INDEX_W  = 4;
    localparam int COUNT_W      = 32;

    localparam int COUNT_RST_W  = 5;
    localparam int STEP_SIZE_W  = 8;
    localparam int OFFSET_W     = 8;
    localparam int WEIGHT_W     = 17;
    localparam int WEIGHT_FRAC  = 16;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 17;

    localparam int REM_W        = 5;
    localparam int DIVIDEND_W   = 24;
    localparam int CHUNK_W      = 8;
    localparam int DIV_STEPS    = DIVIDEND_W / CHUNK_W;
    localparam int DIV_CNT_W    = 2;
    localparam int SUM_W        = 10;

    localparam logic [COUNT_RST_W-1:0] POINT_COUNT_RST = 5'd3;
    localparam logic [STEP_SIZE_W-1:0] STEP_SIZE_RST   = 8'd1;
    localparam logic [OFFSET_W-1:0]    OFFSET_RST      = 8'd0;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_RST      = 17'd32768;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_ONE      = 17'd65536;
    localparam logic [DIV_CNT_W-1:0]   DIV_LAST        = 2'(DIV_STEPS - 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SIZE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT      = 2'd3;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEP = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [ENTRY_W-1:0]         entry_index;
        logic signed [COORD_W-1:0]  x_value;
        logic signed [COORD_W-1:0]  y_value;
        logic [RANDOM_W-1:0]        random_value;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic [OUT_INDEX_W-1:0]     attractor_index;
        logic [COUNT_W-1:0]         step_count;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV_A,
        ST_LOAD_B,
        ST_DIV_B,
        ST_READ,
        ST_MUL_X,
        ST_ADD_X,
        ST_MUL_Y,
        ST_ADD_Y,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic write_entry;
        logic set_point;
        logic div_load;
        logic div_sel_sum;
        logic div_step;
        logic take_index;
        logic mul;
        logic add;
        logic sel_y;
        logic count_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/chaos_game_point_step.sv =====
// ----------------------------------------------------------------------------
// chaos_game_point_step
// Chaos-game point generator: loads attractor entries, sets the current
// point and takes steps toward randomly chosen attractors.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken when start is high while busy is low. Kind 0 loads one
// attractor entry, kind 1 sets the current point, kind 2 takes one step
// with the supplied random number, and kind 3 only reports.
// Every item yields one result beat: done is high for exactly one cycle
// with point, attractor index and step count on result.
// A step item keeps busy high through dispatch, two remainder passes, the
// table read, a multiply and an add for x and then for y, and finish; other
// kinds go from dispatch straight to finish. The beat appears at the edge
// where busy falls. The step time is set by two passes of a remainder unit
// reducing eight bits per cycle and by one multiplier shared by both
// coordinates. A new item may start in the cycle in which done is high.
// The user must write registers through cfg_we, cfg_index and cfg_data
// only while busy is low; the block does not enforce this; no read-back.
// Reset clears the point, the index, the step count and the registers to
// their defaults. The attractor table holds no reset value.
// The receiver cannot stall; each result beat must be taken when shown.
// ----------------------------------------------------------------------------
`default_nettype none

module chaos_game_point_step #(
    parameter int MAX_POINTS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire cgps_pkg::item_t                     item,
    output logic                                     done,
    output cgps_pkg::result_t                        result,
    input  wire logic                                cfg_we,
    input  wire logic [cgps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [cgps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    cgps_pkg::ctrl_cmd_t    cmd;
    cgps_pkg::ctrl_status_t status;

    cgps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    cgps_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .done      (done)
    );

endmodule

`default_nettype wire

// ===== rtl/cgps_rem.sv =====
// ----------------------------------------------------------------------------
// cgps_rem
// Iterative remainder unit: reduces a 24-bit dividend modulo a small divisor,
// eight dividend bits per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cgps_rem (
    input  wire logic                                clk,
    input  wire logic                                load,
    input  wire logic                                step,
    input  wire logic [cgps_pkg::DIVIDEND_W-1:0]     dividend,
    input  wire logic [cgps_pkg::REM_W-1:0]          divisor,
    output logic      [cgps_pkg::REM_W-1:0]          remainder
);

    logic [cgps_pkg::DIVIDEND_W-1:0] shift_reg;
    logic [cgps_pkg::REM_W-1:0]      rem_reg;
    logic [cgps_pkg::REM_W-1:0]      rem_next;

    always_comb
    begin
        logic [cgps_pkg::REM_W:0] trial;
        rem_next = rem_reg;
        for (int i = 0; i < cgps_pkg::CHUNK_W; i++)
        begin
            trial = {rem_next, shift_reg[cgps_pkg::DIVIDEND_W-1-i]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            rem_next = trial[cgps_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            shift_reg <= shift_reg << cgps_pkg::CHUNK_W;
            rem_reg   <= rem_next;
        end
    end

    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/cgps_datapath.sv =====
// ----------------------------------------------------------------------------
// cgps_datapath
// Configuration registers, attractor table, current point, index selection
// and the shared movement multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module cgps_datapath #(
    parameter int MAX_POINTS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [cgps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [cgps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire cgps_pkg::item_t                     item,
    input  wire cgps_pkg::ctrl_cmd_t                 cmd,
    output cgps_pkg::ctrl_status_t                   status,
    output cgps_pkg::result_t                        result,
    output logic                                     done
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    cgps_pkg::item_t                      item_reg;
    cgps_pkg::result_t                    result_reg;
    logic                                 done_reg;

    logic [cgps_pkg::COUNT_RST_W-1:0]     point_count_reg;
    logic [cgps_pkg::STEP_SIZE_W-1:0]     step_size_reg;
    logic [cgps_pkg::OFFSET_W-1:0]        offset_reg;
    logic [cgps_pkg::WEIGHT_W-1:0]        weight_reg;

    logic signed [cgps_pkg::COORD_W-1:0]  cur_x_reg;
    logic signed [cgps_pkg::COORD_W-1:0]  cur_y_reg;
    logic [IDX_W-1:0]                     cur_idx_reg;
    logic [cgps_pkg::COUNT_W-1:0]         step_count_reg;

    logic signed [cgps_pkg::COORD_W-1:0]  mem_x [MAX_POINTS];
    logic signed [cgps_pkg::COORD_W-1:0]  mem_y [MAX_POINTS];
    logic signed [cgps_pkg::COORD_W-1:0]  rd_x_reg;
    logic signed [cgps_pkg::COORD_W-1:0]  rd_y_reg;

    logic signed [cgps_pkg::COORD_W+cgps_pkg::WEIGHT_W:0] prod_reg;

    logic [cgps_pkg::REM_W-1:0]           active_n;
    logic [cgps_pkg::WEIGHT_W-1:0]        weight_sat;
    logic [cgps_pkg::DIVIDEND_W-1:0]      dividend;
    logic [cgps_pkg::SUM_W-1:0]           index_sum;
    logic [cgps_pkg::REM_W-1:0]           remainder;
    logic                                 entry_ok;

    logic signed [cgps_pkg::COORD_W-1:0]  target;
    logic signed [cgps_pkg::COORD_W-1:0]  origin;
    logic signed [cgps_pkg::COORD_W:0]    diff;
    logic signed [cgps_pkg::WEIGHT_W:0]   weight_s;
    logic signed [cgps_pkg::COORD_W+cgps_pkg::WEIGHT_W:0] prod_shift;
    logic signed [cgps_pkg::COORD_W-1:0]  moved;

    always_comb
    begin
        if (point_count_reg == '0)
        begin
            active_n = cgps_pkg::REM_W'(1);
        end
        else if (32'(point_count_reg) > MAX_POINTS)
        begin
            active_n = cgps_pkg::REM_W'(MAX_POINTS);
        end
        else
        begin
            active_n = point_count_reg;
        end
    end

    assign weight_sat = weight_reg[cgps_pkg::WEIGHT_W-1] ? cgps_pkg::WEIGHT_ONE : weight_reg;

    assign index_sum = cgps_pkg::SUM_W'(cur_idx_reg) + cgps_pkg::SUM_W'(offset_reg)
                     + cgps_pkg::SUM_W'(remainder);

    assign dividend = cmd.div_sel_sum
                    ? cgps_pkg::DIVIDEND_W'(index_sum)
                    : cgps_pkg::DIVIDEND_W'(step_size_reg * item_reg.random_value);

    cgps_rem u_rem (
        .clk       (clk),
        .load      (cmd.div_load),
        .step      (cmd.div_step),
        .dividend  (dividend),
        .divisor   (active_n),
        .remainder (remainder)
    );

    assign entry_ok = 32'(item_reg.entry_index) < MAX_POINTS;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && entry_ok)
        begin
            mem_x[IDX_W'(item_reg.entry_index)] <= item_reg.x_value;
            mem_y[IDX_W'(item_reg.entry_index)] <= item_reg.y_value;
        end
        if (cmd.take_index)
        begin
            rd_x_reg <= mem_x[IDX_W'(remainder)];
            rd_y_reg <= mem_y[IDX_W'(remainder)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= cgps_pkg::POINT_COUNT_RST;
            step_size_reg   <= cgps_pkg::STEP_SIZE_RST;
            offset_reg      <= cgps_pkg::OFFSET_RST;
            weight_reg      <= cgps_pkg::WEIGHT_RST;
            cur_idx_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cgps_pkg::CFG_POINT_COUNT:
                begin
                    point_count_reg <= cfg_data[cgps_pkg::COUNT_RST_W-1:0];
                    cur_idx_reg     <= '0;
                end
                cgps_pkg::CFG_STEP_SIZE:
                begin
                    step_size_reg <= cfg_data[cgps_pkg::STEP_SIZE_W-1:0];
                    cur_idx_reg   <= '0;
                end
                cgps_pkg::CFG_OFFSET:
                begin
                    offset_reg  <= cfg_data[cgps_pkg::OFFSET_W-1:0];
                    cur_idx_reg <= '0;
                end
                cgps_pkg::CFG_WEIGHT:
                begin
                    weight_reg <= cfg_data[cgps_pkg::WEIGHT_W-1:0];
                end
            endcase
        end
        else if (cmd.take_index)
        begin
            cur_idx_reg <= IDX_W'(remainder);
        end
    end

    assign target     = cmd.sel_y ? rd_y_reg : rd_x_reg;
    assign origin     = cmd.sel_y ? cur_y_reg : cur_x_reg;
    assign diff       = {target[cgps_pkg::COORD_W-1], target}
                      - {origin[cgps_pkg::COORD_W-1], origin};
    assign weight_s   = $signed({1'b0, weight_sat});
    assign prod_shift = prod_reg >>> cgps_pkg::WEIGHT_FRAC;
    assign moved      = origin + prod_shift[cgps_pkg::COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= diff * weight_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            step_count_reg <= '0;
        end
        else
        begin
            if (cmd.set_point)
            begin
                cur_x_reg <= item_reg.x_value;
                cur_y_reg <= item_reg.y_value;
            end
            else if (cmd.add && !cmd.sel_y)
            begin
                cur_x_reg <= moved;
            end
            else if (cmd.add && cmd.sel_y)
            begin
                cur_y_reg <= moved;
            end
            if (cmd.count_step && (step_count_reg != '1))
            begin
                step_count_reg <= step_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.point_x         <= cur_x_reg;
            result_reg.point_y         <= cur_y_reg;
            result_reg.attractor_index <= cgps_pkg::OUT_INDEX_W'(cur_idx_reg);
            result_reg.step_count      <= step_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign status.kind = item_reg.kind;
    assign result      = result_reg;
    assign done        = done_reg;

endmodule

`default_nettype wire

// ===== rtl/cgps_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgps_ctrl
// Sequencer that walks the datapath through one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cgps_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire cgps_pkg::ctrl_status_t  status,
    output cgps_pkg::ctrl_cmd_t          cmd,
    output logic                         busy
);

    cgps_pkg::ctrl_state_t               state_reg;
    cgps_pkg::ctrl_state_t               state_next;
    logic [cgps_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [cgps_pkg::DIV_CNT_W-1:0]      cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cgps_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            cgps_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cgps_pkg::ST_DISPATCH;
                end
            end
            cgps_pkg::ST_DISPATCH:
            begin
                cnt_next = '0;
                if (status.kind == cgps_pkg::KIND_STEP)
                begin
                    state_next = cgps_pkg::ST_DIV_A;
                end
                else
                begin
                    state_next = cgps_pkg::ST_FINISH;
                end
            end
            cgps_pkg::ST_DIV_A:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == cgps_pkg::DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = cgps_pkg::ST_LOAD_B;
                end
            end
            cgps_pkg::ST_LOAD_B:
            begin
                state_next = cgps_pkg::ST_DIV_B;
            end
            cgps_pkg::ST_DIV_B:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == cgps_pkg::DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = cgps_pkg::ST_READ;
                end
            end
            cgps_pkg::ST_READ:   state_next = cgps_pkg::ST_MUL_X;
            cgps_pkg::ST_MUL_X:  state_next = cgps_pkg::ST_ADD_X;
            cgps_pkg::ST_ADD_X:  state_next = cgps_pkg::ST_MUL_Y;
            cgps_pkg::ST_MUL_Y:  state_next = cgps_pkg::ST_ADD_Y;
            cgps_pkg::ST_ADD_Y:  state_next = cgps_pkg::ST_FINISH;
            cgps_pkg::ST_FINISH: state_next = cgps_pkg::ST_IDLE;
            default:             state_next = cgps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            cgps_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            cgps_pkg::ST_DISPATCH:
            begin
                unique case (status.kind)
                    cgps_pkg::KIND_LOAD: cmd.write_entry = 1'b1;
                    cgps_pkg::KIND_SET:  cmd.set_point   = 1'b1;
                    cgps_pkg::KIND_STEP: cmd.div_load    = 1'b1;
                    default:             cmd.div_load    = 1'b0;
                endcase
            end
            cgps_pkg::ST_DIV_A:
            begin
                cmd.div_step = 1'b1;
            end
            cgps_pkg::ST_LOAD_B:
            begin
                cmd.div_load    = 1'b1;
                cmd.div_sel_sum = 1'b1;
            end
            cgps_pkg::ST_DIV_B:
            begin
                cmd.div_step = 1'b1;
            end
            cgps_pkg::ST_READ:
            begin
                cmd.take_index = 1'b1;
            end
            cgps_pkg::ST_MUL_X:
            begin
                cmd.mul = 1'b1;
            end
            cgps_pkg::ST_ADD_X:
            begin
                cmd.add = 1'b1;
            end
            cgps_pkg::ST_MUL_Y:
            begin
                cmd.mul   = 1'b1;
                cmd.sel_y = 1'b1;
            end
            cgps_pkg::ST_ADD_Y:
            begin
                cmd.add        = 1'b1;
                cmd.sel_y      = 1'b1;
                cmd.count_step = 1'b1;
            end
            cgps_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cgps_checker.sv =====
// ----------------------------------------------------------------------------
// cgps_checker
// Port-level checks of the start/busy/done sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module cgps_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire logic done
);

    property p_accept_sets_busy;
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy;
    endproperty

    property p_no_done_after_accept;
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done;
    endproperty

    property p_done_ends_busy;
        @(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy));
    endproperty

    property p_done_single_beat;
        @(posedge clk) disable iff (!rst_n)
        done |=> !done;
    endproperty

    property p_busy_fall_gives_done;
        @(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done;
    endproperty

    a_accept_sets_busy:     assert property (p_accept_sets_busy)
        else $error("busy did not rise after an accepted item");
    a_no_done_after_accept: assert property (p_no_done_after_accept)
        else $error("result beat right after acceptance");
    a_done_ends_busy:       assert property (p_done_ends_busy)
        else $error("result beat without a finished item");
    a_done_single_beat:     assert property (p_done_single_beat)
        else $error("result beat lasted more than one cycle");
    a_busy_fall_gives_done: assert property (p_busy_fall_gives_done)
        else $error("item finished without a result beat");

endmodule

bind chaos_game_point_step cgps_checker u_cgps_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
